FILE: src/assert_macros.svh
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an implication at every clock edge outside reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// check a property at every clock edge, reset included
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`endif

FILE: src/i2c_ee_pkg.sv
// Types and constants of the I2C EEPROM byte access core
package i2c_ee_pkg;

  localparam int unsigned PhaseW = 4;
  localparam int unsigned ByteW  = 2;

  typedef logic [PhaseW-1:0] phase_t;
  typedef logic [ByteW-1:0]  byte_no_t;

  localparam phase_t PH_IDLE       = 4'd0;
  localparam phase_t PH_RS_LOW     = 4'd1;
  localparam phase_t PH_RS_HIGH    = 4'd2;
  localparam phase_t PH_START_FALL = 4'd3;
  localparam phase_t PH_TX_LOW     = 4'd4;
  localparam phase_t PH_TX_HIGH    = 4'd5;
  localparam phase_t PH_ACK_LOW    = 4'd6;
  localparam phase_t PH_ACK_HIGH   = 4'd7;
  localparam phase_t PH_RX_LOW     = 4'd8;
  localparam phase_t PH_RX_HIGH    = 4'd9;
  localparam phase_t PH_NACK_LOW   = 4'd10;
  localparam phase_t PH_NACK_HIGH  = 4'd11;
  localparam phase_t PH_STOP_LOW   = 4'd12;
  localparam phase_t PH_STOP_HIGH  = 4'd13;
  localparam phase_t PH_STOP_RISE  = 4'd14;

  localparam byte_no_t BYTE_DEVICE  = 2'd0;
  localparam byte_no_t BYTE_ADDRESS = 2'd1;
  localparam byte_no_t BYTE_DATA    = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic CFG_DEVICE_SELECT  = 1'b0;
  localparam logic CFG_ACK_WAIT_LIMIT = 1'b1;

  localparam logic [6:0] DEVICE_SELECT_RST  = 7'd80;
  localparam logic [7:0] ACK_WAIT_LIMIT_RST = 8'd250;
  localparam logic [2:0] LAST_BIT           = 3'd7;

endpackage

FILE: src/i2c_eeprom_byte_access_core.sv
// I2C master sequencer for single-byte EEPROM write and random read
// Output: the result of a transfer is registered and presented on the output in the cycle after it.
// Throughput: one input transfer per cycle while in_ready_o is high; each transfer is one half-bit bus tick.
// The input is ready whenever the output register is empty or being drained.
// Reset releases the bus (idle sequencer, read_data zero), device_select 80,
// ack_wait_limit 250.
`include "assert_macros.svh"

module i2c_eeprom_byte_access_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       start_request_i,
  input  logic       command_i,
  input  logic [7:0] mem_address_i,
  input  logic [7:0] write_data_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_out_o,
  output logic       sda_out_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] read_data_o
);

  logic [6:0] device_select_q;
  logic [7:0] ack_limit_q;

  i2c_ee_pkg::phase_t   phase_q, phase_d;
  i2c_ee_pkg::byte_no_t byte_q, byte_d;
  logic [2:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] ack_cnt_q, ack_cnt_d;
  logic [7:0] held_addr_q, held_addr_d;
  logic [7:0] held_data_q, held_data_d;
  logic       held_cmd_q, held_cmd_d;
  logic [7:0] rx_byte_q, rx_byte_d;

  logic scl, sda, busy, done;
  logic in_fire;
  logic out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    phase_d     = phase_q;
    byte_d      = byte_q;
    bit_cnt_d   = bit_cnt_q;
    shift_d     = shift_q;
    ack_cnt_d   = ack_cnt_q;
    held_addr_d = held_addr_q;
    held_data_d = held_data_q;
    held_cmd_d  = held_cmd_q;
    rx_byte_d   = rx_byte_q;
    scl  = 1'b1;
    sda  = 1'b1;
    busy = 1'b1;
    done = 1'b0;
    unique case (phase_q)
      i2c_ee_pkg::PH_RS_LOW: begin
        scl     = 1'b0;
        phase_d = i2c_ee_pkg::PH_RS_HIGH;
      end
      i2c_ee_pkg::PH_RS_HIGH: begin
        phase_d = i2c_ee_pkg::PH_START_FALL;
      end
      i2c_ee_pkg::PH_START_FALL: begin
        sda       = 1'b0;
        shift_d   = {device_select_q, byte_q == i2c_ee_pkg::BYTE_DATA};
        bit_cnt_d = '0;
        phase_d   = i2c_ee_pkg::PH_TX_LOW;
      end
      i2c_ee_pkg::PH_TX_LOW: begin
        scl     = 1'b0;
        sda     = shift_q[7];
        phase_d = i2c_ee_pkg::PH_TX_HIGH;
      end
      i2c_ee_pkg::PH_TX_HIGH: begin
        sda = shift_q[7];
        if (bit_cnt_q == i2c_ee_pkg::LAST_BIT) begin
          bit_cnt_d = '0;
          ack_cnt_d = '0;
          phase_d   = i2c_ee_pkg::PH_ACK_LOW;
        end else begin
          bit_cnt_d = bit_cnt_q + 3'd1;
          shift_d   = {shift_q[6:0], 1'b0};
          phase_d   = i2c_ee_pkg::PH_TX_LOW;
        end
      end
      i2c_ee_pkg::PH_ACK_LOW: begin
        scl     = 1'b0;
        phase_d = i2c_ee_pkg::PH_ACK_HIGH;
      end
      i2c_ee_pkg::PH_ACK_HIGH: begin
        if (sda_in_i && (ack_cnt_q < ack_limit_q)) begin
          ack_cnt_d = ack_cnt_q + 8'd1;
        end else begin
          ack_cnt_d = '0;
          bit_cnt_d = '0;
          if (byte_q == i2c_ee_pkg::BYTE_DEVICE) begin
            shift_d = held_addr_q;
            byte_d  = i2c_ee_pkg::BYTE_ADDRESS;
            phase_d = i2c_ee_pkg::PH_TX_LOW;
          end else if (byte_q == i2c_ee_pkg::BYTE_ADDRESS) begin
            byte_d = i2c_ee_pkg::BYTE_DATA;
            if (held_cmd_q == i2c_ee_pkg::CMD_READ) begin
              phase_d = i2c_ee_pkg::PH_RS_LOW;
            end else begin
              shift_d = held_data_q;
              phase_d = i2c_ee_pkg::PH_TX_LOW;
            end
          end else if (held_cmd_q == i2c_ee_pkg::CMD_READ) begin
            shift_d = '0;
            phase_d = i2c_ee_pkg::PH_RX_LOW;
          end else begin
            phase_d = i2c_ee_pkg::PH_STOP_LOW;
          end
        end
      end
      i2c_ee_pkg::PH_RX_LOW: begin
        scl     = 1'b0;
        phase_d = i2c_ee_pkg::PH_RX_HIGH;
      end
      i2c_ee_pkg::PH_RX_HIGH: begin
        shift_d = {shift_q[6:0], sda_in_i};
        if (bit_cnt_q == i2c_ee_pkg::LAST_BIT) begin
          bit_cnt_d = '0;
          rx_byte_d = {shift_q[6:0], sda_in_i};
          phase_d   = i2c_ee_pkg::PH_NACK_LOW;
        end else begin
          bit_cnt_d = bit_cnt_q + 3'd1;
          phase_d   = i2c_ee_pkg::PH_RX_LOW;
        end
      end
      i2c_ee_pkg::PH_NACK_LOW: begin
        scl     = 1'b0;
        phase_d = i2c_ee_pkg::PH_NACK_HIGH;
      end
      i2c_ee_pkg::PH_NACK_HIGH: begin
        phase_d = i2c_ee_pkg::PH_STOP_LOW;
      end
      i2c_ee_pkg::PH_STOP_LOW: begin
        scl     = 1'b0;
        sda     = 1'b0;
        phase_d = i2c_ee_pkg::PH_STOP_HIGH;
      end
      i2c_ee_pkg::PH_STOP_HIGH: begin
        sda     = 1'b0;
        phase_d = i2c_ee_pkg::PH_STOP_RISE;
      end
      i2c_ee_pkg::PH_STOP_RISE: begin
        done    = 1'b1;
        phase_d = i2c_ee_pkg::PH_IDLE;
        byte_d  = i2c_ee_pkg::BYTE_DEVICE;
      end
      default: begin
        busy    = 1'b0;
        phase_d = i2c_ee_pkg::PH_IDLE;
        byte_d  = i2c_ee_pkg::BYTE_DEVICE;
        if (start_request_i) begin
          held_cmd_d  = command_i;
          held_addr_d = mem_address_i;
          held_data_d = write_data_i;
          bit_cnt_d   = '0;
          ack_cnt_d   = '0;
          busy        = 1'b1;
          phase_d     = i2c_ee_pkg::PH_START_FALL;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_select_q <= i2c_ee_pkg::DEVICE_SELECT_RST;
      ack_limit_q     <= i2c_ee_pkg::ACK_WAIT_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        i2c_ee_pkg::CFG_DEVICE_SELECT:  device_select_q <= cfg_data_i[6:0];
        i2c_ee_pkg::CFG_ACK_WAIT_LIMIT: ack_limit_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= i2c_ee_pkg::PH_IDLE;
      byte_q      <= i2c_ee_pkg::BYTE_DEVICE;
      bit_cnt_q   <= '0;
      shift_q     <= '0;
      ack_cnt_q   <= '0;
      held_addr_q <= '0;
      held_data_q <= '0;
      held_cmd_q  <= i2c_ee_pkg::CMD_WRITE;
      rx_byte_q   <= '0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      byte_q      <= byte_d;
      bit_cnt_q   <= bit_cnt_d;
      shift_q     <= shift_d;
      ack_cnt_q   <= ack_cnt_d;
      held_addr_q <= held_addr_d;
      held_data_q <= held_data_d;
      held_cmd_q  <= held_cmd_d;
      rx_byte_q   <= rx_byte_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_out_o   <= 1'b1;
      sda_out_o   <= 1'b1;
      busy_res_o  <= 1'b0;
      done_res_o  <= 1'b0;
      read_data_o <= '0;
    end else if (in_fire) begin
      scl_out_o   <= scl;
      sda_out_o   <= sda;
      busy_res_o  <= busy;
      done_res_o  <= done;
      read_data_o <= rx_byte_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_CLK(a_done_busy, out_valid_o && done_res_o |-> busy_res_o)
  `ASSERT_CLK(a_idle_no_start,
    in_fire && phase_q == i2c_ee_pkg::PH_IDLE && !start_request_i
    |=> out_valid_o && !busy_res_o)
  `ASSERT_CLK(a_stop_done,
    in_fire && phase_q == i2c_ee_pkg::PH_STOP_RISE |=> out_valid_o && done_res_o)
  `ASSERT_CLK(a_bit_cnt_phase,
    bit_cnt_q == '0 || phase_q == i2c_ee_pkg::PH_TX_LOW ||
    phase_q == i2c_ee_pkg::PH_TX_HIGH || phase_q == i2c_ee_pkg::PH_RX_LOW ||
    phase_q == i2c_ee_pkg::PH_RX_HIGH)
  `ASSERT_CLK(a_ack_cnt_phase,
    ack_cnt_q == '0 || phase_q == i2c_ee_pkg::PH_ACK_HIGH)

endmodule
